// ===== sv/rwlo_pkg.sv =====
package rwlo_pkg;

  // Defaults for the top level parameters
  localparam int DEF_RING_DEPTH = 10;
  localparam int DEF_SIZE_BITS  = 16;

  // Fixed field widths of the channels
  localparam int HANDLE_W   = 32;
  localparam int IN_SIZE_W  = 16;
  localparam int OFF_W      = 20;
  localparam int OUT_SIZE_W = 16;
  localparam int SLOT_W     = 6;

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_APPENDED = 2'd0,
    STATUS_FOUND    = 2'd1,
    STATUS_BEYOND   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

endpackage

// ===== sv/rwlo_if.sv =====
interface rwlo_cmd_if;
  import rwlo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [HANDLE_W-1:0]   record_handle;
  logic [IN_SIZE_W-1:0]  record_size;
  logic [OFF_W-1:0]      byte_offset;

  modport source (output valid, cmd, record_handle, record_size, byte_offset, input ready);
  modport sink   (input valid, cmd, record_handle, record_size, byte_offset, output ready);
endinterface

interface rwlo_res_if;
  import rwlo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [HANDLE_W-1:0]   found_handle;
  logic [OUT_SIZE_W-1:0] found_size;
  logic [OUT_SIZE_W-1:0] offset_in_record;
  logic [SLOT_W-1:0]     found_slot;

  modport source (output valid, status, found_handle, found_size, offset_in_record, found_slot,
                  input ready);
  modport sink   (input valid, status, found_handle, found_size, offset_in_record, found_slot,
                  output ready);
endinterface

// ===== sv/rwlo_ring_mem.sv =====
module rwlo_ring_mem #(
  parameter int RING_DEPTH = rwlo_pkg::DEF_RING_DEPTH,
  parameter int SIZE_BITS  = rwlo_pkg::DEF_SIZE_BITS,
  parameter int POS_W      = $clog2(RING_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [POS_W-1:0]              waddr_i,
  input  logic [rwlo_pkg::HANDLE_W-1:0] whandle_i,
  input  logic [SIZE_BITS-1:0]          wsize_i,
  input  logic [POS_W-1:0]              raddr_i,
  output logic [rwlo_pkg::HANDLE_W-1:0] rhandle_o,
  output logic [SIZE_BITS-1:0]          rsize_o
);
  import rwlo_pkg::*;

  logic [HANDLE_W-1:0]  handle_mem [RING_DEPTH];
  logic [SIZE_BITS-1:0] size_mem   [RING_DEPTH];

  // Store a record at the write slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      handle_mem[waddr_i] <= whandle_i;
      size_mem[waddr_i]   <= wsize_i;
    end
  end

  // Registered read of one record per cycle
  always_ff @(posedge clk_i) begin
    rhandle_o <= handle_mem[raddr_i];
    rsize_o   <= size_mem[raddr_i];
  end

endmodule

// ===== sv/rwlo_span_unit.sv =====
module rwlo_span_unit #(
  parameter int SIZE_BITS = rwlo_pkg::DEF_SIZE_BITS,
  parameter int BASE_W    = rwlo_pkg::DEF_SIZE_BITS + 4
) (
  input  logic [BASE_W-1:0]               base_i,
  input  logic [SIZE_BITS-1:0]            size_i,
  input  logic [rwlo_pkg::OFF_W-1:0]      offset_i,
  output logic [BASE_W-1:0]               sum_o,
  output logic                            hit_o,
  output logic [rwlo_pkg::OUT_SIZE_W-1:0] rel_o
);
  import rwlo_pkg::*;

  localparam int CMP_W = (BASE_W > OFF_W) ? BASE_W : OFF_W;

  logic [CMP_W-1:0] diff;

  // End of this record's span, and whether the offset falls before it
  assign sum_o = base_i + BASE_W'(size_i);
  assign hit_o = CMP_W'(offset_i) < CMP_W'(sum_o);

  // Position inside the record, valid when the offset is at or past base
  assign diff  = CMP_W'(offset_i) - CMP_W'(base_i);
  assign rel_o = diff[OUT_SIZE_W-1:0];

endmodule

// ===== sv/ring_write_log_offset_locate.sv =====
// Ring of write records with byte offset lookup.
// cmd_i carries one command word: append stores record_handle and
// record_size at the write slot (the oldest record is overwritten once the
// ring is full); locate searches for byte_offset across the stored records,
// oldest first. res_o returns one result word per command: status, and for
// a hit the record's handle, size, offset inside it and ring slot.
// Timing: cmd_i.ready is high only while the sequencer is idle. An append
// passes through the finish state to the output register, and a new
// command is taken only once the sequencer is idle again. A locate walks
// the stored records oldest first up to the hit before its finish state,
// visiting all valid records (at most RING_DEPTH) on a miss; the add/compare
// unit checks one record per cycle during the walk, fed by the single read
// port of the record memory.
// The result sits in an output register; a new command is accepted while it
// waits, and the sequencer holds its next result until res_o.ready frees the
// register.
// Reset empties the ring (write and read slots zero, not full) and drops any
// pending result. Record storage itself is not cleared.
module ring_write_log_offset_locate #(
  parameter int RING_DEPTH = rwlo_pkg::DEF_RING_DEPTH,
  parameter int SIZE_BITS  = rwlo_pkg::DEF_SIZE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwlo_cmd_if.sink   cmd_i,
  rwlo_res_if.source res_o
);
  import rwlo_pkg::*;

  localparam int POS_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int BASE_W = SIZE_BITS + CNT_W;

  state_e state_q, state_d;
  logic [POS_W-1:0] wp_q, wp_d, rp_q, rp_d, idx_q, idx_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [OFF_W-1:0]  off_q, off_d;

  status_e               res_status_q, res_status_d;
  logic [HANDLE_W-1:0]   res_handle_q, res_handle_d;
  logic [OUT_SIZE_W-1:0] res_size_q, res_size_d;
  logic [OUT_SIZE_W-1:0] res_offs_q, res_offs_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [HANDLE_W-1:0]   out_handle_q;
  logic [OUT_SIZE_W-1:0] out_size_q;
  logic [OUT_SIZE_W-1:0] out_offs_q;
  logic [SLOT_W-1:0]     out_slot_q;

  logic                  cmd_acc, out_free, out_load, mem_we;
  logic [POS_W-1:0]      wp_next, rp_next, idx_next, rd_addr;
  logic [CNT_W-1:0]      live_cnt;
  logic [SIZE_BITS-1:0]  size_in, rd_size;
  logic [HANDLE_W-1:0]   rd_handle;
  logic [OUT_SIZE_W-1:0] rd_size16, span_rel;
  logic [BASE_W-1:0]     span_sum;
  logic                  span_hit;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign out_load    = (state_q == ST_FIN) && out_free;

  // Fit the incoming size to the stored width, and the stored size to the output
  if (SIZE_BITS >= IN_SIZE_W) begin : g_size_in_ext
    assign size_in = SIZE_BITS'(cmd_i.record_size);
  end else begin : g_size_in_cut
    assign size_in = cmd_i.record_size[SIZE_BITS-1:0];
  end
  if (SIZE_BITS >= OUT_SIZE_W) begin : g_size_out_cut
    assign rd_size16 = rd_size[OUT_SIZE_W-1:0];
  end else begin : g_size_out_ext
    assign rd_size16 = OUT_SIZE_W'(rd_size);
  end

  // Advance ring positions with wrap
  assign wp_next  = (wp_q == POS_W'(RING_DEPTH - 1)) ? '0 : wp_q + POS_W'(1);
  assign rp_next  = (rp_q == POS_W'(RING_DEPTH - 1)) ? '0 : rp_q + POS_W'(1);
  assign idx_next = (idx_q == POS_W'(RING_DEPTH - 1)) ? '0 : idx_q + POS_W'(1);

  // Number of valid records
  always_comb begin
    if (full_q) begin
      live_cnt = CNT_W'(RING_DEPTH);
    end else if (wp_q >= rp_q) begin
      live_cnt = CNT_W'(wp_q) - CNT_W'(rp_q);
    end else begin
      live_cnt = CNT_W'(wp_q) + CNT_W'(RING_DEPTH) - CNT_W'(rp_q);
    end
  end

  // Read the oldest record on acceptance, then the next one during the walk
  assign rd_addr = (state_q == ST_WALK) ? idx_next : rp_q;

  rwlo_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .SIZE_BITS  (SIZE_BITS),
    .POS_W      (POS_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (wp_q),
    .whandle_i (cmd_i.record_handle),
    .wsize_i   (size_in),
    .raddr_i   (rd_addr),
    .rhandle_o (rd_handle),
    .rsize_o   (rd_size)
  );

  rwlo_span_unit #(
    .SIZE_BITS (SIZE_BITS),
    .BASE_W    (BASE_W)
  ) u_span (
    .base_i   (base_q),
    .size_i   (rd_size),
    .offset_i (off_q),
    .sum_o    (span_sum),
    .hit_o    (span_hit),
    .rel_o    (span_rel)
  );

  // Sequencer: next state, ring update and walk
  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    full_d       = full_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_size_d   = res_size_q;
    res_offs_d   = res_offs_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          res_handle_d = '0;
          res_size_d   = '0;
          res_offs_d   = '0;
          res_slot_d   = '0;
          if (cmd_i.cmd == CMD_APPEND) begin
            mem_we       = 1'b1;
            rp_d         = full_q ? rp_next : rp_q;
            wp_d         = wp_next;
            if (wp_next == rp_d) begin
              full_d = 1'b1;
            end
            res_status_d = STATUS_APPENDED;
            state_d      = ST_FIN;
          end else begin
            idx_d   = rp_q;
            base_d  = '0;
            off_d   = cmd_i.byte_offset;
            cnt_d   = live_cnt;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (cnt_q == '0) begin
          res_status_d = STATUS_BEYOND;
          state_d      = ST_FIN;
        end else if (span_hit) begin
          res_status_d = STATUS_FOUND;
          res_handle_d = rd_handle;
          res_size_d   = rd_size16;
          res_offs_d   = span_rel;
          res_slot_d   = SLOT_W'(idx_q);
          state_d      = ST_FIN;
        end else begin
          base_d = span_sum;
          idx_d  = idx_next;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold walk and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    base_q       <= base_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_size_q   <= res_size_d;
    res_offs_q   <= res_offs_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_size_q   <= res_size_q;
      out_offs_q   <= res_offs_q;
      out_slot_q   <= res_slot_q;
    end
  end

  // Fill the output register, drop the word once taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.status           = out_status_q;
  assign res_o.found_handle     = out_handle_q;
  assign res_o.found_size       = out_size_q;
  assign res_o.offset_in_record = out_offs_q;
  assign res_o.found_slot       = out_slot_q;

  // A full ring has its read slot at the write slot
  a_full_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (rp_q == wp_q))
    else $error("full ring with read and write slots apart");

  // The read slot only moves once the ring has filled
  a_rp_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> (rp_q == '0))
    else $error("read slot moved before ring was full");

  // Walk never visits more records than the ring holds
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= CNT_W'(RING_DEPTH)))
    else $error("walk count beyond ring depth");

  // An accepted locate starts the walk
  a_locate_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (cmd_i.cmd == CMD_LOCATE)) |=> (state_q == ST_WALK))
    else $error("locate did not start the walk");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rwlo_pkg::*;

  localparam int RING_SLOTS  = DEF_RING_DEPTH;
  localparam int SIZE_W      = DEF_SIZE_BITS;
  localparam int RANDOM_WORDS = 1200;
  localparam int QUIET_WORDS  = 200;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic                 op;
    logic [HANDLE_W-1:0]  handle;
    logic [IN_SIZE_W-1:0] nbytes;
    logic [OFF_W-1:0]     offset;
  } ring_cmd_t;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   handle;
    logic [OUT_SIZE_W-1:0] nbytes;
    logic [OUT_SIZE_W-1:0] offs;
    logic [SLOT_W-1:0]     slot;
  } ring_result_t;

  // Shadow copy of the record ring plus the results still owed by the block
  class ring_log_model;
    logic [HANDLE_W-1:0] slot_handle [RING_SLOTS];
    logic [SIZE_W-1:0]   slot_size   [RING_SLOTS];
    int unsigned         wr_slot;
    int unsigned         rd_slot;
    bit                  full;
    ring_result_t        pending_results [$];
    int unsigned         mismatches;

    function new();
      wr_slot    = 0;
      rd_slot    = 0;
      full       = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
    endfunction

    function int unsigned live_records();
      if (full) return RING_SLOTS;
      if (wr_slot >= rd_slot) return wr_slot - rd_slot;
      return wr_slot + RING_SLOTS - rd_slot;
    endfunction

    // Total bytes held by the valid records
    function longint unsigned stored_bytes();
      longint unsigned total;
      int unsigned     idx;
      total = 0;
      idx   = rd_slot;
      for (int i = 0; i < live_records(); i++) begin
        total += slot_size[idx];
        idx = next_slot(idx);
      end
      return total;
    endfunction

    // Apply one accepted command word and queue the result it owes
    function void note_command(ring_cmd_t w);
      ring_result_t    r;
      int unsigned     idx;
      int unsigned     n;
      longint unsigned base;
      longint unsigned diff;
      bit              hit;
      r = '0;
      if (w.op == CMD_APPEND) begin
        slot_handle[wr_slot] = w.handle;
        slot_size[wr_slot]   = w.nbytes[SIZE_W-1:0];
        // Overwrite the oldest record once the ring is full
        if (full) rd_slot = next_slot(rd_slot);
        wr_slot = next_slot(wr_slot);
        if (wr_slot == rd_slot) full = 1'b1;
        r.status = STATUS_APPENDED;
      end else begin
        r.status = STATUS_BEYOND;
        idx  = rd_slot;
        base = 0;
        hit  = 1'b0;
        n    = live_records();
        // Walk oldest to newest; zero-size records never match
        for (int i = 0; i < n && !hit; i++) begin
          if (w.offset < base + slot_size[idx]) begin
            hit      = 1'b1;
            diff     = w.offset - base;
            r.status = STATUS_FOUND;
            r.handle = slot_handle[idx];
            r.nbytes = slot_size[idx];
            r.offs   = diff[OUT_SIZE_W-1:0];
            r.slot   = idx[SLOT_W-1:0];
          end else begin
            base += slot_size[idx];
            idx = next_slot(idx);
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one result word with the oldest expectation
    task check_result(ring_result_t got);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word, status %0d", got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.handle !== want.handle)
        report_mismatch($sformatf("found_handle got %h want %h", got.handle, want.handle));
      if (got.nbytes !== want.nbytes)
        report_mismatch($sformatf("found_size got %0d want %0d", got.nbytes, want.nbytes));
      if (got.offs !== want.offs)
        report_mismatch($sformatf("offset_in_record got %0d want %0d", got.offs, want.offs));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("found_slot got %0d want %0d", got.slot, want.slot));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet_phase;
  int unsigned cycle_count;
  ring_log_model log_model;

  rwlo_cmd_if cmd_bus ();
  rwlo_res_if res_bus ();

  ring_write_log_offset_locate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Throttle the result side in random bursts
  initial begin
    int n;
    res_bus.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        n = $urandom_range(1, 15);
      end else begin
        res_bus.ready <= 1'b1;
        n = $urandom_range(1, 24);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // Check every result word taken by the handshake
  always @(posedge clk_i) begin
    ring_result_t got;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.status = status_e'(res_bus.status);
      got.handle = res_bus.found_handle;
      got.nbytes = res_bus.found_size;
      got.offs   = res_bus.offset_in_record;
      got.slot   = res_bus.found_slot;
      log_model.check_result(got);
    end
  end

  // Present one command word and hold it until accepted
  task automatic send_word(input logic op, input logic [HANDLE_W-1:0] h,
                           input logic [IN_SIZE_W-1:0] n, input logic [OFF_W-1:0] o);
    ring_cmd_t w;
    w.op     = op;
    w.handle = h;
    w.nbytes = n;
    w.offset = o;
    cmd_bus.valid         <= 1'b1;
    cmd_bus.cmd           <= op;
    cmd_bus.record_handle <= h;
    cmd_bus.record_size   <= n;
    cmd_bus.byte_offset   <= o;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    log_model.note_command(w);
  endtask

  task automatic idle_sender(input int n);
    cmd_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off new commands until every owed result has arrived
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (log_model.pending_results.size() != 0);
  endtask

  task automatic locate_at(input longint unsigned off);
    send_word(CMD_LOCATE, $urandom, IN_SIZE_W'($urandom), off[OFF_W-1:0]);
  endtask

  // Build one random command word, offsets biased toward the stored span
  task automatic random_word();
    logic [IN_SIZE_W-1:0] n;
    longint unsigned      total;
    int                   pick;
    if ($urandom_range(0, 99) < 45) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      n = '0;
      else if (pick == 1) n = '1;
      else if (pick < 6)  n = IN_SIZE_W'($urandom_range(1, 64));
      else                n = IN_SIZE_W'($urandom);
      send_word(CMD_APPEND, $urandom, n, OFF_W'($urandom));
    end else begin
      total = log_model.stored_bytes();
      pick  = $urandom_range(0, 19);
      if (pick < 2)                    locate_at(0);
      else if (pick < 4)               locate_at(total);
      else if (pick == 4 && total > 0) locate_at(total - 1);
      else if (pick < 9)               locate_at($urandom);
      else if (total > 0)              locate_at($urandom_range(0, total - 1));
      else                             locate_at($urandom);
    end
  endtask

  initial begin
    log_model = new();
    quiet_phase = 1'b0;
    rst_ni                = 1'b0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.cmd           = CMD_APPEND;
    cmd_bus.record_handle = '0;
    cmd_bus.record_size   = '0;
    cmd_bus.byte_offset   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ring, zero-size record, extremes of size, handle and offset
    locate_at(0);
    locate_at('hFFFFF);
    send_word(CMD_APPEND, '0, '0, '1);
    locate_at(0);
    send_word(CMD_APPEND, '1, '1, '0);
    locate_at(0);
    locate_at('hFFFE);
    locate_at('hFFFF);
    send_word(CMD_APPEND, 32'hA5A5_5A5A, 16'd1, '0);
    locate_at('hFFFF);
    locate_at('hFFFFF);
    // Fill the ring, then wrap so the oldest records get overwritten
    for (int i = 0; i < 9; i++)
      send_word(CMD_APPEND, $urandom, (i == 4) ? 16'd0 : 16'hFFFF, OFF_W'($urandom));
    locate_at(0);
    locate_at(log_model.stored_bytes() - 1);
    locate_at(log_model.stored_bytes());
    drain_results();

    // Random traffic; pause once midway until the block is empty
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) drain_results();
      if (k == RANDOM_WORDS - QUIET_WORDS) quiet_phase = 1'b1;
      random_word();
      if (!quiet_phase && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 15));
    end
    drain_results();
    repeat (20) @(posedge clk_i);

    if (log_model.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
